FILE: design/stereo_varispeed_pitch_shifter_top_assert.svh
// Assertion macros shared by the pitch shifter RTL.
`ifndef STEREO_VARISPEED_PITCH_SHIFTER_TOP_ASSERT_SVH
`define STEREO_VARISPEED_PITCH_SHIFTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SVPS_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SVPS_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/svps_pkg.sv
// Package: widths, register indexes, controller states and command structs.
package svps_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 16;
    localparam int ADDR_BITS   = 12;
    localparam int RING_DEPTH  = 1 << ADDR_BITS;
    localparam int POS_BITS    = ADDR_BITS + FRAC_BITS;
    localparam int RATE_BITS   = 19;
    localparam int MIX_BITS    = 17;
    localparam int CFG_BITS    = 19;
    localparam int DATA_BITS   = 2 * SAMPLE_BITS;

    localparam logic [RATE_BITS-1:0] RATE_RESET = RATE_BITS'(65536);
    localparam logic [MIX_BITS-1:0]  MIX_ONE    = MIX_BITS'(65536);

    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_ENABLE    = 2'd0;
    localparam cfg_index_t CFG_READ_RATE = 2'd1;
    localparam cfg_index_t CFG_WET_MIX   = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_READ0,
        ST_READ1,
        ST_MUL_INTERP,
        ST_WET,
        ST_MUL_MIX,
        ST_MIX,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clear_wr;
        logic load_in;
        logic ring_wr;
        logic rd_i0;
        logic rd_i1;
        logic save_r0;
        logic mul_interp;
        logic calc_wet;
        logic mul_mix;
        logic calc_mix;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic enable;
    } status_t;

endpackage

FILE: design/svps_datapath.sv
// Datapath: rings, pointers, interpolation and mix arithmetic, config and output registers.
module svps_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  svps_pkg::cmd_t                 cmd,
    output svps_pkg::status_t              stat,
    input  logic [svps_pkg::DATA_BITS-1:0] s_tdata,
    input  logic                           s_tlast,
    input  logic                           cfg_wr_en,
    input  logic [1:0]                     cfg_index,
    input  logic [svps_pkg::CFG_BITS-1:0]  cfg_wdata,
    output logic [svps_pkg::DATA_BITS-1:0] m_tdata,
    output logic                           m_tlast
);
    import svps_pkg::*;

    localparam int PROD1_BITS = SAMPLE_BITS + 1 + FRAC_BITS + 1;
    localparam int PROD2_BITS = SAMPLE_BITS + 1 + MIX_BITS + 1;
    localparam int MIX_SHIFT  = 16;

    // configuration
    logic                 enable_reg;
    logic [RATE_BITS-1:0] read_rate_reg;
    logic [MIX_BITS-1:0]  wet_mix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= 1'b0;
            read_rate_reg <= RATE_RESET;
            wet_mix_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ENABLE:    enable_reg    <= cfg_wdata[0];
                CFG_READ_RATE: read_rate_reg <= cfg_wdata[RATE_BITS-1:0];
                CFG_WET_MIX:   wet_mix_reg   <= cfg_wdata[MIX_BITS-1:0];
                default:       ;
            endcase
        end
    end

    // pointers and clear counter
    logic [ADDR_BITS-1:0] clr_cnt_reg;
    logic [ADDR_BITS-1:0] wr_idx_reg;
    logic [POS_BITS-1:0]  pos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            wr_idx_reg  <= '0;
            pos_reg     <= '0;
        end else begin
            if (cmd.clear_wr) clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cmd.calc_mix) begin
                wr_idx_reg <= wr_idx_reg + 1'b1;
                pos_reg    <= pos_reg + POS_BITS'(read_rate_reg);
            end
        end
    end

    assign stat.clear_last = (clr_cnt_reg == ADDR_BITS'(RING_DEPTH - 1));
    assign stat.enable     = enable_reg;

    logic [ADDR_BITS-1:0] idx0;
    logic [FRAC_BITS-1:0] frac;
    assign idx0 = pos_reg[POS_BITS-1:FRAC_BITS];
    assign frac = pos_reg[FRAC_BITS-1:0];

    // input capture
    logic signed [SAMPLE_BITS-1:0] dry_l_reg, dry_r_reg;
    logic                          last_reg;

    // ring memories, single port each
    logic [ADDR_BITS-1:0]   ring_addr;
    logic                   ring_we;
    logic [SAMPLE_BITS-1:0] ring_wl, ring_wr;

    always_comb begin
        ring_we = cmd.clear_wr | cmd.ring_wr;
        ring_wl = cmd.clear_wr ? '0 : dry_l_reg;
        ring_wr = cmd.clear_wr ? '0 : dry_r_reg;
        if (cmd.clear_wr)   ring_addr = clr_cnt_reg;
        else if (cmd.rd_i0) ring_addr = idx0;
        else if (cmd.rd_i1) ring_addr = idx0 + 1'b1;
        else                ring_addr = wr_idx_reg;
    end

    logic [SAMPLE_BITS-1:0] left_ring  [RING_DEPTH];
    logic [SAMPLE_BITS-1:0] right_ring [RING_DEPTH];
    logic signed [SAMPLE_BITS-1:0] rd_l_reg, rd_r_reg;

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            left_ring[ring_addr]  <= ring_wl;
            right_ring[ring_addr] <= ring_wr;
        end
        rd_l_reg <= left_ring[ring_addr];
        rd_r_reg <= right_ring[ring_addr];
    end

    // arithmetic
    logic signed [SAMPLE_BITS-1:0] r0_l_reg, r0_r_reg;
    logic signed [PROD1_BITS-1:0]  p1_l_reg, p1_r_reg;
    logic signed [SAMPLE_BITS-1:0] wet_l_reg, wet_r_reg;
    logic signed [PROD2_BITS-1:0]  p2_l_reg, p2_r_reg;
    logic signed [SAMPLE_BITS-1:0] res_l_reg, res_r_reg;
    logic                          res_last_reg;

    logic signed [SAMPLE_BITS:0]   d1_l, d1_r, d2_l, d2_r;
    logic signed [FRAC_BITS:0]     frac_s;
    logic [MIX_BITS-1:0]           m_sat;
    logic signed [MIX_BITS:0]      m_s;
    logic signed [PROD1_BITS-1:0]  p1_l_rnd, p1_r_rnd;
    logic signed [PROD2_BITS-1:0]  p2_l_rnd, p2_r_rnd;
    logic signed [SAMPLE_BITS+2:0] wet_l_sum, wet_r_sum, mix_l_sum, mix_r_sum;

    always_comb begin
        d1_l   = {rd_l_reg[SAMPLE_BITS-1], rd_l_reg} - {r0_l_reg[SAMPLE_BITS-1], r0_l_reg};
        d1_r   = {rd_r_reg[SAMPLE_BITS-1], rd_r_reg} - {r0_r_reg[SAMPLE_BITS-1], r0_r_reg};
        d2_l   = {wet_l_reg[SAMPLE_BITS-1], wet_l_reg} - {dry_l_reg[SAMPLE_BITS-1], dry_l_reg};
        d2_r   = {wet_r_reg[SAMPLE_BITS-1], wet_r_reg} - {dry_r_reg[SAMPLE_BITS-1], dry_r_reg};
        frac_s = $signed({1'b0, frac});
        m_sat  = (wet_mix_reg > MIX_ONE) ? MIX_ONE : wet_mix_reg;
        m_s    = $signed({1'b0, m_sat});
        // round half up, then floor shift
        p1_l_rnd = p1_l_reg + $signed(PROD1_BITS'(1) << (FRAC_BITS - 1));
        p1_r_rnd = p1_r_reg + $signed(PROD1_BITS'(1) << (FRAC_BITS - 1));
        p2_l_rnd = p2_l_reg + $signed(PROD2_BITS'(1) << (MIX_SHIFT - 1));
        p2_r_rnd = p2_r_reg + $signed(PROD2_BITS'(1) << (MIX_SHIFT - 1));
        wet_l_sum = (SAMPLE_BITS+3)'(r0_l_reg) + (SAMPLE_BITS+3)'(p1_l_rnd >>> FRAC_BITS);
        wet_r_sum = (SAMPLE_BITS+3)'(r0_r_reg) + (SAMPLE_BITS+3)'(p1_r_rnd >>> FRAC_BITS);
        mix_l_sum = (SAMPLE_BITS+3)'(dry_l_reg) + (SAMPLE_BITS+3)'(p2_l_rnd >>> MIX_SHIFT);
        mix_r_sum = (SAMPLE_BITS+3)'(dry_r_reg) + (SAMPLE_BITS+3)'(p2_r_rnd >>> MIX_SHIFT);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            dry_l_reg    <= s_tdata[SAMPLE_BITS-1:0];
            dry_r_reg    <= s_tdata[DATA_BITS-1:SAMPLE_BITS];
            last_reg     <= s_tlast;
            // pass-through result, overwritten by the mix when enabled
            res_l_reg    <= s_tdata[SAMPLE_BITS-1:0];
            res_r_reg    <= s_tdata[DATA_BITS-1:SAMPLE_BITS];
            res_last_reg <= s_tlast;
        end
        if (cmd.save_r0) begin
            r0_l_reg <= rd_l_reg;
            r0_r_reg <= rd_r_reg;
        end
        if (cmd.mul_interp) begin
            p1_l_reg <= d1_l * frac_s;
            p1_r_reg <= d1_r * frac_s;
        end
        if (cmd.calc_wet) begin
            wet_l_reg <= wet_l_sum[SAMPLE_BITS-1:0];
            wet_r_reg <= wet_r_sum[SAMPLE_BITS-1:0];
        end
        if (cmd.mul_mix) begin
            p2_l_reg <= d2_l * m_s;
            p2_r_reg <= d2_r * m_s;
        end
        if (cmd.calc_mix) begin
            res_l_reg    <= mix_l_sum[SAMPLE_BITS-1:0];
            res_r_reg    <= mix_r_sum[SAMPLE_BITS-1:0];
            res_last_reg <= last_reg;
        end
    end

    // output register
    logic [DATA_BITS-1:0] out_data_reg;
    logic                 out_last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg <= {res_r_reg, res_l_reg};
            out_last_reg <= res_last_reg;
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tlast = out_last_reg;

endmodule

FILE: design/svps_controller.sv
// Controller: sequencing state machine and output valid flag.
`include "stereo_varispeed_pitch_shifter_top_assert.svh"

module svps_controller (
    input  logic                aclk,
    input  logic                aresetn,
    input  svps_pkg::status_t   stat,
    output svps_pkg::cmd_t      cmd,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready
);
    import svps_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_xfer, out_free;

    assign in_xfer  = s_tvalid & s_tready;
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:      if (stat.clear_last) state_next = ST_IDLE;
            ST_IDLE:       if (in_xfer) state_next = stat.enable ? ST_WRITE : ST_FINISH;
            ST_WRITE:      state_next = ST_READ0;
            ST_READ0:      state_next = ST_READ1;
            ST_READ1:      state_next = ST_MUL_INTERP;
            ST_MUL_INTERP: state_next = ST_WET;
            ST_WET:        state_next = ST_MUL_MIX;
            ST_MUL_MIX:    state_next = ST_MIX;
            ST_MIX:        state_next = ST_FINISH;
            ST_FINISH:     if (out_free) state_next = ST_IDLE;
            default:       state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:      cmd.clear_wr = 1'b1;
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = in_xfer;
            end
            ST_WRITE:      cmd.ring_wr = 1'b1;
            ST_READ0:      cmd.rd_i0 = 1'b1;
            ST_READ1: begin
                cmd.rd_i1   = 1'b1;
                cmd.save_r0 = 1'b1;
            end
            ST_MUL_INTERP: cmd.mul_interp = 1'b1;
            ST_WET:        cmd.calc_wet = 1'b1;
            ST_MUL_MIX:    cmd.mul_mix = 1'b1;
            ST_MIX:        cmd.calc_mix = 1'b1;
            ST_FINISH:     cmd.load_out = out_free;
            default:       ;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)                   out_valid_next = 1'b1;
        else if (out_valid_reg && m_tready) out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    `SVPS_ASSERT_NEXT(a_enabled_goes_to_write, aclk, aresetn, in_xfer && stat.enable, state_reg == ST_WRITE, "enabled transfer did not start a ring write")
    `SVPS_ASSERT_NEXT(a_one_item_at_a_time, aclk, aresetn, in_xfer, !s_tready, "input accepted twice in a row")
    `SVPS_ASSERT_NEXT(a_load_sets_valid, aclk, aresetn, cmd.load_out, m_tvalid, "loaded result not presented")
    `SVPS_ASSERT_NEXT(a_finish_waits, aclk, aresetn, state_reg == ST_FINISH && out_valid_reg && !m_tready, state_reg == ST_FINISH, "result overwrote an untaken output")

endmodule

FILE: design/stereo_varispeed_pitch_shifter_top.sv
// Top level: stereo delay-line pitch shifter with linear interpolation and dry/wet mix.
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+--------------------------------------
//  s_       | in        | s_tvalid/s_tready | tdata: left_in, right_in; tlast: block_end
//  m_       | out       | m_tvalid/m_tready | tdata: left_out, right_out; tlast: block_end_out
//  cfg_     | in        | cfg_wr_en         | cfg_index, cfg_wdata (no read-back)
//
// Enabled: after the input transfer come the ring write, two interpolation reads on each
// single-port ring and two multiply/add pairs, then the output load in finish.
// Disabled: the transfer goes straight to finish. Each item is loaded before the next is taken.
// Reset clears both rings, one entry a cycle (s_tready low); config writes go on.
// A waiting result lets the next transfer in; m_tready low holds the one after in finish.
module stereo_varispeed_pitch_shifter_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // left_in [23:0], right_in [47:24]
    input  logic [svps_pkg::DATA_BITS-1:0] s_tdata,
    input  logic                           s_tlast,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // left_out [23:0], right_out [47:24]
    output logic [svps_pkg::DATA_BITS-1:0] m_tdata,
    output logic                           m_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // 0 enable, 1 read_rate, 2 wet_mix
    input  logic                           cfg_wr_en,
    input  logic [1:0]                     cfg_index,
    input  logic [svps_pkg::CFG_BITS-1:0]  cfg_wdata
);
    import svps_pkg::*;

    cmd_t    cmd;
    status_t stat;

    // sequencing
    svps_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .stat     (stat),
        .cmd      (cmd),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // rings, pointers, arithmetic
    svps_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
